### rtl/core/fwig_pkg.sv
// ----------------------------------------------------------------------------
// fwig_pkg
// shared constants, register indexes and types for the wavenumber index
// generator
// ----------------------------------------------------------------------------
package fwig_pkg;

    localparam int DIMS      = 4;
    localparam int SIZE_MAX  = 1024;
    localparam int SIZE_W    = 11;
    localparam int COORD_W   = 10;
    localparam int WAVE_W    = 10;
    localparam int COUNT_W   = 40;
    localparam int DIM_CNT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_D3   = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [COORD_W-1:0] half;
        logic               active;
    } dim_cfg_t;

    typedef struct packed {
        logic signed [WAVE_W-1:0] wave;
        logic                     is_half;
        logic                     carry;
        logic [COORD_W-1:0]       coord_next;
    } dim_res_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] n;
        n = raw;
        if (raw == '0)
            n = SIZE_W'(1);
        else if (raw > SIZE_W'(SIZE_MAX))
            n = SIZE_W'(SIZE_MAX);
        return n;
    endfunction

    function automatic logic [DIM_CNT_W-1:0] clamp_dims(input logic [DIM_CNT_W-1:0] raw);
        logic [DIM_CNT_W-1:0] d;
        d = raw;
        if (raw == '0)
            d = DIM_CNT_W'(1);
        else if (raw > DIM_CNT_W'(DIMS))
            d = DIM_CNT_W'(DIMS);
        return d;
    endfunction

endpackage

### rtl/core/fft_wavenumber_index_generator.sv
// ----------------------------------------------------------------------------
// fft_wavenumber_index_generator
// row-major grid walker giving linear index, signed wavenumbers and nyquist
// ordinal for every grid point
// ----------------------------------------------------------------------------
// Each accepted word produces one result word in the next cycle, and a new word
// is taken every cycle while the output is taken (one grid point per clock).
// All work for a point is a single pass from the coordinate and count
// registers to the output register; the longest path is the carry ripple
// through the four dimension digits plus the 40-bit count increment. A
// result waiting at the output does not stop the next word as long as the
// output is taken in the same cycle. Any write to a listed configuration
// register restarts the walk at the origin; sizes of 0 act as 1, sizes above
// 1024 act as 1024, and a dimension count outside 1..4 is clamped the same way.
module fft_wavenumber_index_generator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [fwig_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fwig_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    restart,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [fwig_pkg::COUNT_W-1:0]            linear_index,
    output logic signed [fwig_pkg::WAVE_W-1:0]      wave_d0,
    output logic signed [fwig_pkg::WAVE_W-1:0]      wave_d1,
    output logic signed [fwig_pkg::WAVE_W-1:0]      wave_d2,
    output logic signed [fwig_pkg::WAVE_W-1:0]      wave_d3,
    output logic                                    is_half,
    output logic [fwig_pkg::COUNT_W-1:0]            half_ordinal,
    output logic                                    last
);

    fwig_pkg::dim_cfg_t [fwig_pkg::DIMS-1:0] dim_cfg;
    fwig_pkg::dim_res_t [fwig_pkg::DIMS-1:0] dim_res;
    logic                                    walk_clear;

    logic [fwig_pkg::COORD_W-1:0] coord_reg [fwig_pkg::DIMS];
    logic [fwig_pkg::COORD_W-1:0] coord_base [fwig_pkg::DIMS];
    logic [fwig_pkg::COUNT_W-1:0] point_count_reg;
    logic [fwig_pkg::COUNT_W-1:0] half_count_reg;
    logic [fwig_pkg::COUNT_W-1:0] point_base;
    logic [fwig_pkg::COUNT_W-1:0] half_base;
    logic [fwig_pkg::DIMS:0]      carry;
    logic [fwig_pkg::DIMS-1:0]    half_vec;
    logic                         any_half;
    logic                         accept;

    logic                                out_valid_reg;
    logic [fwig_pkg::COUNT_W-1:0]        linear_index_reg;
    logic signed [fwig_pkg::WAVE_W-1:0]  wave_reg [fwig_pkg::DIMS];
    logic                                is_half_reg;
    logic [fwig_pkg::COUNT_W-1:0]        half_ordinal_reg;
    logic                                last_reg;

    fwig_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .dim_cfg    (dim_cfg),
        .walk_clear (walk_clear)
    );

    // restart takes effect before this point is emitted
    always_comb
    begin
        for (int i = 0; i < fwig_pkg::DIMS; i++)
        begin
            coord_base[i] = restart ? '0 : coord_reg[i];
        end
        point_base = restart ? '0 : point_count_reg;
        half_base  = restart ? '0 : half_count_reg;
    end

    // fastest digit is the highest index; carry ripples toward dimension 0
    assign carry[fwig_pkg::DIMS] = 1'b1;

    for (genvar j = 0; j < fwig_pkg::DIMS; j++)
    begin : g_dim
        fwig_dim u_dim (
            .cfg      (dim_cfg[j]),
            .coord    (coord_base[j]),
            .carry_in (carry[j+1]),
            .res      (dim_res[j])
        );
        assign carry[j]    = dim_res[j].carry;
        assign half_vec[j] = dim_res[j].is_half;
    end

    assign any_half = |half_vec;
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fwig_pkg::DIMS; i++)
            begin
                coord_reg[i] <= '0;
            end
            point_count_reg <= '0;
            half_count_reg  <= '0;
        end
        else if (walk_clear)
        begin
            for (int i = 0; i < fwig_pkg::DIMS; i++)
            begin
                coord_reg[i] <= '0;
            end
            point_count_reg <= '0;
            half_count_reg  <= '0;
        end
        else if (accept)
        begin
            if (carry[0])
            begin
                for (int i = 0; i < fwig_pkg::DIMS; i++)
                begin
                    coord_reg[i] <= '0;
                end
                point_count_reg <= '0;
                half_count_reg  <= '0;
            end
            else
            begin
                for (int i = 0; i < fwig_pkg::DIMS; i++)
                begin
                    coord_reg[i] <= dim_res[i].coord_next;
                end
                point_count_reg <= point_base + fwig_pkg::COUNT_W'(1);
                half_count_reg  <= half_base + fwig_pkg::COUNT_W'(any_half);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            linear_index_reg <= point_base;
            for (int i = 0; i < fwig_pkg::DIMS; i++)
            begin
                wave_reg[i] <= dim_res[i].wave;
            end
            is_half_reg      <= any_half;
            half_ordinal_reg <= any_half ? half_base : '0;
            last_reg         <= carry[0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign linear_index = linear_index_reg;
    assign wave_d0      = wave_reg[0];
    assign wave_d1      = wave_reg[1];
    assign wave_d2      = wave_reg[2];
    assign wave_d3      = wave_reg[3];
    assign is_half      = is_half_reg;
    assign half_ordinal = half_ordinal_reg;
    assign last         = last_reg;

    // the final point of a walk leaves both counts at zero
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && carry[0] |=> point_count_reg == '0 && half_count_reg == '0)
        else $error("counts not cleared after final grid point");

    // flagged points are a subset of emitted points
    a_half_le_point: assert property (@(posedge clk) disable iff (!rst_n)
        half_count_reg <= point_count_reg)
        else $error("half count ran ahead of point count");

    // coordinates never reach their dimension size
    for (genvar k = 0; k < fwig_pkg::DIMS; k++)
    begin : g_chk
        a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
            {1'b0, coord_reg[k]} < dim_cfg[k].size)
            else $error("coordinate out of range");
    end

endmodule

### rtl/core/fwig_cfg.sv
// ----------------------------------------------------------------------------
// fwig_cfg
// configuration registers, held as clamped sizes and dimension count
// ----------------------------------------------------------------------------
module fwig_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fwig_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fwig_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fwig_pkg::dim_cfg_t [fwig_pkg::DIMS-1:0] dim_cfg,
    output logic                                walk_clear
);

    logic [fwig_pkg::DIM_CNT_W-1:0] dims_reg;
    logic [fwig_pkg::SIZE_W-1:0]    size_reg [fwig_pkg::DIMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= fwig_pkg::DIM_CNT_W'(1);
            for (int i = 0; i < fwig_pkg::DIMS; i++)
            begin
                size_reg[i] <= fwig_pkg::SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fwig_pkg::REG_DIM_COUNT:
                    dims_reg <= fwig_pkg::clamp_dims(cfg_data[fwig_pkg::DIM_CNT_W-1:0]);
                fwig_pkg::REG_SIZE_D0: size_reg[0] <= fwig_pkg::clamp_size(cfg_data);
                fwig_pkg::REG_SIZE_D1: size_reg[1] <= fwig_pkg::clamp_size(cfg_data);
                fwig_pkg::REG_SIZE_D2: size_reg[2] <= fwig_pkg::clamp_size(cfg_data);
                fwig_pkg::REG_SIZE_D3: size_reg[3] <= fwig_pkg::clamp_size(cfg_data);
                default: ;
            endcase
        end
    end

    // any listed register restarts the walk
    assign walk_clear = cfg_we && (cfg_index <= fwig_pkg::REG_SIZE_D3);

    for (genvar j = 0; j < fwig_pkg::DIMS; j++)
    begin : g_dim
        assign dim_cfg[j].size   = size_reg[j];
        assign dim_cfg[j].half   = size_reg[j][fwig_pkg::SIZE_W-1:1];
        assign dim_cfg[j].active = fwig_pkg::DIM_CNT_W'(j) < dims_reg;
    end

endmodule

### rtl/core/fwig_dim.sv
// ----------------------------------------------------------------------------
// fwig_dim
// one digit of the mixed-radix walk: wavenumber, nyquist flag and increment
// ----------------------------------------------------------------------------
module fwig_dim (
    input  fwig_pkg::dim_cfg_t               cfg,
    input  logic [fwig_pkg::COORD_W-1:0]     coord,
    input  logic                             carry_in,
    output fwig_pkg::dim_res_t               res
);

    logic [fwig_pkg::SIZE_W-1:0] coord_ext;
    logic [fwig_pkg::SIZE_W-1:0] coord_inc;
    logic [fwig_pkg::SIZE_W-1:0] diff;
    logic                        wrap;
    logic                        above;
    logic                        at_half;

    always_comb
    begin
        coord_ext = {1'b0, coord};
        coord_inc = coord_ext + fwig_pkg::SIZE_W'(1);
        diff      = coord_ext - cfg.size;
        wrap      = coord_inc >= cfg.size;
        above     = coord_ext > {1'b0, cfg.half};
        at_half   = coord == cfg.half;

        res.wave = '0;
        if (cfg.active && above)
            res.wave = diff[fwig_pkg::WAVE_W-1:0];
        else if (cfg.active && !at_half)
            res.wave = coord[fwig_pkg::WAVE_W-1:0];

        res.is_half = cfg.active && at_half;

        // unused dimensions pass the carry straight on
        res.carry      = cfg.active ? (carry_in && wrap) : carry_in;
        res.coord_next = coord;
        if (cfg.active && carry_in)
            res.coord_next = wrap ? '0 : coord_inc[fwig_pkg::COORD_W-1:0];
    end

endmodule

### tb/sv/fft_wavenumber_index_generator_test.sv
// ----------------------------------------------------------------------------
// fft_wavenumber_index_generator_test
// Self-checking bench for the grid walker. A driver sends restart words
// with random gaps, and a monitor stalls the output at random and checks
// every result against an in-bench model of the walk. The configuration
// changes between phases, once all results of a phase are in.
// ----------------------------------------------------------------------------
module fft_wavenumber_index_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [fwig_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = fwig_pkg::REG_SIZE_D3 + 3'd1;
    localparam logic [fwig_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    typedef struct packed {
        logic [fwig_pkg::COUNT_W-1:0]                       linear_index;
        logic [fwig_pkg::DIMS-1:0][fwig_pkg::WAVE_W-1:0]    wave;
        logic                                               is_half;
        logic [fwig_pkg::COUNT_W-1:0]                       half_ordinal;
        logic                                               last;
    } grid_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [fwig_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fwig_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic restart = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [fwig_pkg::COUNT_W-1:0] linear_index;
    logic signed [fwig_pkg::WAVE_W-1:0] wave_d0;
    logic signed [fwig_pkg::WAVE_W-1:0] wave_d1;
    logic signed [fwig_pkg::WAVE_W-1:0] wave_d2;
    logic signed [fwig_pkg::WAVE_W-1:0] wave_d3;
    logic is_half;
    logic [fwig_pkg::COUNT_W-1:0] half_ordinal;
    logic last;

    // walk state as the block should hold it
    logic [fwig_pkg::DIM_CNT_W-1:0] dims_reg;
    logic [fwig_pkg::SIZE_W-1:0] size_reg [fwig_pkg::DIMS];
    logic [fwig_pkg::COORD_W-1:0] coord_now [fwig_pkg::DIMS];
    logic [fwig_pkg::COUNT_W-1:0] point_cnt;
    logic [fwig_pkg::COUNT_W-1:0] half_cnt;

    bit pending_restarts [$];
    grid_point_t expected_points [$];
    grid_point_t want_pt;
    int queued = 0;
    int accepted = 0;
    int checked = 0;
    int mismatches = 0;
    int cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit calm = 1'b0;

    fft_wavenumber_index_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .linear_index (linear_index),
        .wave_d0      (wave_d0),
        .wave_d1      (wave_d1),
        .wave_d2      (wave_d2),
        .wave_d3      (wave_d3),
        .is_half      (is_half),
        .half_ordinal (half_ordinal),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic void clear_walk();
        int d;
        for (d = 0; d < fwig_pkg::DIMS; d++)
            coord_now[d] = '0;
        point_cnt = '0;
        half_cnt = '0;
    endfunction

    function automatic int active_dims();
        int nd;
        nd = int'(dims_reg);
        if (nd == 0)
            nd = 1;
        else if (nd > fwig_pkg::DIMS)
            nd = fwig_pkg::DIMS;
        return nd;
    endfunction

    function automatic logic [fwig_pkg::SIZE_W-1:0] span_of(input int d);
        logic [fwig_pkg::SIZE_W-1:0] n;
        n = size_reg[d];
        if (n == '0)
            n = fwig_pkg::SIZE_W'(1);
        else if (n > fwig_pkg::SIZE_W'(fwig_pkg::SIZE_MAX))
            n = fwig_pkg::SIZE_W'(fwig_pkg::SIZE_MAX);
        return n;
    endfunction

    function automatic void apply_reg_write(input logic [fwig_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [fwig_pkg::CFG_DATA_W-1:0] data);
        if (idx == fwig_pkg::REG_DIM_COUNT) begin
            dims_reg = data[fwig_pkg::DIM_CNT_W-1:0];
            clear_walk();
        end else if (idx <= fwig_pkg::REG_SIZE_D3) begin
            size_reg[idx - fwig_pkg::REG_SIZE_D0] = data;
            clear_walk();
        end
    endfunction

    function automatic grid_point_t grid_next_point(input logic rs);
        grid_point_t p;
        int nd;
        int d;
        logic [fwig_pkg::SIZE_W-1:0] n;
        logic [fwig_pkg::SIZE_W-1:0] h;
        logic [fwig_pkg::SIZE_W-1:0] c;
        logic [fwig_pkg::SIZE_W-1:0] diff;
        logic flag;
        logic wrap;
        p = '0;
        if (rs)
            clear_walk();
        nd = active_dims();
        flag = 1'b0;
        for (d = 0; d < nd; d++) begin
            n = span_of(d);
            h = n >> 1;
            c = {1'b0, coord_now[d]};
            if (c > h) begin
                diff = c - n;
                p.wave[d] = diff[fwig_pkg::WAVE_W-1:0];
            end else if (c == h) begin
                p.wave[d] = '0;
                flag = 1'b1;
            end else begin
                p.wave[d] = c[fwig_pkg::WAVE_W-1:0];
            end
        end
        // mixed-radix increment, last active dimension fastest
        wrap = 1'b1;
        for (d = nd - 1; d >= 0 && wrap; d--) begin
            n = span_of(d);
            if ({1'b0, coord_now[d]} + fwig_pkg::SIZE_W'(1) >= n) begin
                coord_now[d] = '0;
            end else begin
                coord_now[d] = coord_now[d] + fwig_pkg::COORD_W'(1);
                wrap = 1'b0;
            end
        end
        p.linear_index = point_cnt;
        p.is_half = flag;
        p.half_ordinal = flag ? half_cnt : '0;
        p.last = wrap;
        if (wrap) begin
            clear_walk();
        end else begin
            point_cnt = point_cnt + fwig_pkg::COUNT_W'(1);
            if (flag)
                half_cnt = half_cnt + fwig_pkg::COUNT_W'(1);
        end
        return p;
    endfunction

    task automatic check_field(input string name,
                               input logic [fwig_pkg::COUNT_W-1:0] want,
                               input logic [fwig_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s, word %0d: expected %h, got %h",
                         name, checked, want, got);
        end
    endtask

    task automatic write_reg(input logic [fwig_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fwig_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_reg_write(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_point(input bit rs);
        pending_restarts.push_back(rs);
        queued++;
    endtask

    task automatic queue_points(input int count, input int restart_odds);
        int k;
        @(negedge clk);
        for (k = 0; k < count; k++)
            push_point(restart_odds > 0 && $urandom_range(restart_odds - 1, 0) == 0);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted != queued || expected_points.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [fwig_pkg::CFG_DATA_W-1:0] random_dims_word();
        logic [fwig_pkg::DIM_CNT_W-1:0] v;
        if ($urandom_range(7, 0) == 0)
            v = fwig_pkg::DIM_CNT_W'($urandom);
        else
            v = fwig_pkg::DIM_CNT_W'($urandom_range(fwig_pkg::DIMS, 1));
        return {(fwig_pkg::CFG_DATA_W - fwig_pkg::DIM_CNT_W)'($urandom), v};
    endfunction

    function automatic logic [fwig_pkg::CFG_DATA_W-1:0] random_size();
        case ($urandom_range(15, 0))
            0: return '0;
            1: return fwig_pkg::CFG_DATA_W'($urandom_range(2047, fwig_pkg::SIZE_MAX + 1));
            2: return fwig_pkg::CFG_DATA_W'(fwig_pkg::SIZE_MAX);
            default: return fwig_pkg::CFG_DATA_W'($urandom_range(9, 1));
        endcase
    endfunction

    // driver: presents queued restart words, with random gaps between words
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            restart <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                expected_points.push_back(grid_next_point(restart));
                accepted++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (!calm && pending_restarts.size() > 0
                             && $urandom_range(9, 0) == 0) begin
                    in_gap = $urandom_range(13, 1) - 1;
                    in_valid <= 1'b0;
                end else if (pending_restarts.size() > 0) begin
                    in_valid <= 1'b1;
                    restart <= pending_restarts.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random output stalls and the word-by-word check
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: linear_index %h", linear_index);
                end else begin
                    want_pt = expected_points.pop_front();
                    check_field("linear_index", want_pt.linear_index, linear_index);
                    check_field("wave_d0", fwig_pkg::COUNT_W'(want_pt.wave[0]),
                                fwig_pkg::COUNT_W'($unsigned(wave_d0)));
                    check_field("wave_d1", fwig_pkg::COUNT_W'(want_pt.wave[1]),
                                fwig_pkg::COUNT_W'($unsigned(wave_d1)));
                    check_field("wave_d2", fwig_pkg::COUNT_W'(want_pt.wave[2]),
                                fwig_pkg::COUNT_W'($unsigned(wave_d2)));
                    check_field("wave_d3", fwig_pkg::COUNT_W'(want_pt.wave[3]),
                                fwig_pkg::COUNT_W'($unsigned(wave_d3)));
                    check_field("is_half", fwig_pkg::COUNT_W'(want_pt.is_half),
                                fwig_pkg::COUNT_W'(is_half));
                    check_field("half_ordinal", want_pt.half_ordinal, half_ordinal);
                    check_field("last", fwig_pkg::COUNT_W'(want_pt.last),
                                fwig_pkg::COUNT_W'(last));
                    checked++;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(11, 0) == 0) begin
                out_gap = $urandom_range(13, 1) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int total;
        int nd;
        int d;
        dims_reg = fwig_pkg::DIM_CNT_W'(1);
        for (d = 0; d < fwig_pkg::DIMS; d++)
            size_reg[d] = fwig_pkg::SIZE_W'(1);
        clear_walk();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting: a single point of size one, flagged and last every time
        @(negedge clk);
        push_point(1'b1);
        push_point(1'b0);
        wait_drained();

        // dimension count of zero acts as one; nyquist bin and negative side
        write_reg(fwig_pkg::REG_DIM_COUNT, 11'h7F8);
        write_reg(fwig_pkg::REG_SIZE_D0, 11'd5);
        queue_points(6, 0);
        wait_drained();

        // count above the maximum, oversize and zero sizes, restart mid-walk
        write_reg(fwig_pkg::REG_DIM_COUNT, 11'h507);
        write_reg(fwig_pkg::REG_SIZE_D0, 11'd2);
        write_reg(fwig_pkg::REG_SIZE_D1, 11'h7FF);
        write_reg(fwig_pkg::REG_SIZE_D2, 11'd0);
        write_reg(fwig_pkg::REG_SIZE_D3, 11'd3);
        @(negedge clk);
        push_point(1'b0);
        push_point(1'b0);
        push_point(1'b0);
        push_point(1'b0);
        push_point(1'b1);
        push_point(1'b0);
        wait_drained();

        // writes beyond the register list must leave the walk alone
        write_reg(REG_SPARE_LO, fwig_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, fwig_pkg::CFG_DATA_W'($urandom));
        queue_points(3, 0);
        wait_drained();

        write_reg(fwig_pkg::REG_DIM_COUNT, 11'd4);
        write_reg(fwig_pkg::REG_SIZE_D0, 11'd1025);
        write_reg(fwig_pkg::REG_SIZE_D1, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D2, 11'd1024);
        write_reg(fwig_pkg::REG_SIZE_D3, 11'd2);
        queue_points(3, 0);
        wait_drained();

        // full-size slow dimension, far enough to pass the nyquist bin
        write_reg(fwig_pkg::REG_DIM_COUNT, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D0, fwig_pkg::CFG_DATA_W'(fwig_pkg::SIZE_MAX));
        queue_points(530, 0);
        wait_drained();
        total = 530;

        // odd full size on the fastest active dimension, the rest of size one
        nd = $urandom_range(fwig_pkg::DIMS, 2);
        write_reg(fwig_pkg::REG_DIM_COUNT, fwig_pkg::CFG_DATA_W'(nd));
        write_reg(fwig_pkg::REG_SIZE_D0, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D1, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D2, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D3, 11'd1);
        write_reg(fwig_pkg::REG_SIZE_D0 + fwig_pkg::CFG_IDX_W'(nd - 1),
                  fwig_pkg::CFG_DATA_W'(fwig_pkg::SIZE_MAX - 1));
        queue_points(530, 0);
        wait_drained();
        total += 530;

        while (total < 1700) begin
            if ($urandom_range(3, 0) != 0)
                write_reg(fwig_pkg::REG_DIM_COUNT, random_dims_word());
            if ($urandom_range(1, 0) != 0)
                write_reg(fwig_pkg::REG_SIZE_D0, random_size());
            if ($urandom_range(1, 0) != 0)
                write_reg(fwig_pkg::REG_SIZE_D1, random_size());
            if ($urandom_range(1, 0) != 0)
                write_reg(fwig_pkg::REG_SIZE_D2, random_size());
            if ($urandom_range(1, 0) != 0)
                write_reg(fwig_pkg::REG_SIZE_D3, random_size());
            if ($urandom_range(5, 0) == 0)
                write_reg(fwig_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                          fwig_pkg::CFG_DATA_W'($urandom));
            if (total >= 1600)
                calm = 1'b1;
            nd = $urandom_range(90, 10);
            queue_points(nd, 12);
            wait_drained();
            total += nd;
        end

        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
